/* rtl/mlbc_pkg.sv */
package mlbc_pkg;

  // Width of the level and blink status fields in every result item.
  localparam int OUT_W = 6;

  // Command codes carried by in_cmd.
  typedef enum logic [2:0] {
    CMD_SET      = 3'd0,
    CMD_TOGGLE   = 3'd1,
    CMD_BLINK    = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_BLINK_N  = 3'd4,
    CMD_TICK     = 3'd5
  } cmd_code_t;

  // Operation applied to one channel in a given cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_TOGGLE,
    OP_BLINK,
    OP_STOP,
    OP_TICK
  } chan_op_t;

  // Per-channel command bundle from the decoder.
  typedef struct packed {
    chan_op_t    op;
    logic        level;
    logic [15:0] interval;
    logic [15:0] cycles;
    logic        endless;
  } chan_cmd_t;

endpackage

/* rtl/multi_led_blink_controller_top.sv */
// Channel   Handshake          Fields
// input     start / busy       in_cmd, in_led_index, in_level, in_interval, in_blink_count
// result    out_valid strobe   out_led_levels, out_blinking, out_accepted
//
// One item is taken in every cycle; busy stays low. The item is registered in
// the input register, then all channels update in parallel logic and the result
// register loads their new state, so a result is shown from the result register.
// Reset is synchronous and active low and restores every channel at once.
// The receiver cannot stall: each result is shown for one cycle only.
module multi_led_blink_controller_top
  import mlbc_pkg::*;
#(
  parameter int NUM_LEDS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    in_cmd,
  input  logic [2:0]    in_led_index,
  input  logic          in_level,
  input  logic [15:0]   in_interval,
  input  logic [15:0]   in_blink_count,
  output logic          out_valid,
  output logic [OUT_W-1:0] out_led_levels,
  output logic [OUT_W-1:0] out_blinking,
  output logic          out_accepted
);

  logic        in_valid_r;
  logic [2:0]  cmd_r, idx_r;
  logic        level_r;
  logic [15:0] interval_r, count_r;

  logic                out_valid_r, out_accepted_r;
  logic [OUT_W-1:0]    out_levels_r, out_blinking_r;
  logic [OUT_W-1:0]    levels_nxt, blinking_nxt;

  logic                idx_ok, acc_nxt;
  chan_op_t            op_sel;
  chan_cmd_t           ccmd [NUM_LEDS];
  logic [NUM_LEDS-1:0] chan_level, chan_mode;
  logic [NUM_LEDS-1:0] chan_mode_q;

  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    cmd_r      <= in_cmd;
    idx_r      <= in_led_index;
    level_r    <= in_level;
    interval_r <= in_interval;
    count_r    <= in_blink_count;
  end

  // Command decode and acceptance.
  assign idx_ok = ({1'b0, idx_r} < 4'(NUM_LEDS));

  always_comb begin
    op_sel  = OP_NONE;
    acc_nxt = 1'b0;
    case (cmd_r)
      CMD_TICK: begin
        op_sel  = OP_TICK;
        acc_nxt = 1'b1;
      end
      CMD_SET: begin
        op_sel  = OP_SET;
        acc_nxt = idx_ok;
      end
      CMD_TOGGLE: begin
        op_sel  = OP_TOGGLE;
        acc_nxt = idx_ok;
      end
      CMD_STOP: begin
        op_sel  = OP_STOP;
        acc_nxt = idx_ok;
      end
      CMD_BLINK: begin
        op_sel  = OP_BLINK;
        acc_nxt = idx_ok && (interval_r != 16'd0);
      end
      CMD_BLINK_N: begin
        op_sel  = OP_BLINK;
        acc_nxt = idx_ok && (interval_r != 16'd0) && (count_r != 16'd0);
      end
      default: begin
      end
    endcase
  end

  // Channels: a tick goes to all, any other accepted item to the addressed one.
  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_chan
    always_comb begin
      ccmd[i].level    = level_r;
      ccmd[i].interval = interval_r;
      ccmd[i].cycles   = (cmd_r == CMD_BLINK_N) ? count_r : 16'd0;
      ccmd[i].endless  = (cmd_r == CMD_BLINK);
      if (in_valid_r && acc_nxt && ((op_sel == OP_TICK) || (idx_r == 3'(i)))) begin
        ccmd[i].op = op_sel;
      end else begin
        ccmd[i].op = OP_NONE;
      end
    end

    mlbc_channel #(
      .RESET_LEVEL((i % 2) == 0)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (ccmd[i]),
      .level_nxt(chan_level[i]),
      .mode_nxt (chan_mode[i])
    );
  end

  // Status fields show channels that exist; higher bits read zero.
  for (genvar j = 0; j < OUT_W; j++) begin : g_out
    if (j < NUM_LEDS) begin : g_has
      assign levels_nxt[j]   = chan_level[j];
      assign blinking_nxt[j] = chan_mode[j];
    end else begin : g_none
      assign levels_nxt[j]   = 1'b0;
      assign blinking_nxt[j] = 1'b0;
    end
  end

  // Result register, loaded with the state after the item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
    if (in_valid_r) begin
      out_levels_r   <= levels_nxt;
      out_blinking_r <= blinking_nxt;
      out_accepted_r <= acc_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_levels = out_levels_r;
  assign out_blinking   = out_blinking_r;
  assign out_accepted   = out_accepted_r;

  // Blink status after each cycle, kept for the channel check below.
  always_ff @(posedge clk) begin
    chan_mode_q <= chan_mode;
  end

  // Every item taken gives its result after the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("item without result");

  // An ignored item directly after another leaves the reported state alone.
  a_ignored_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted && $past(out_valid))
      |-> ($stable(out_led_levels) && $stable(out_blinking)))
    else $error("ignored item changed state");

  // Any item other than a tick changes the blink status of one channel at most.
  a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && (cmd_r != CMD_TICK))
      |=> ($countones(chan_mode_q ^ $past(chan_mode_q)) <= 1))
    else $error("item touched more than one channel");

endmodule

/* rtl/mlbc_channel.sv */
module mlbc_channel
  import mlbc_pkg::*;
#(
  parameter logic RESET_LEVEL = 1'b0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  chan_cmd_t cmd,
  output logic      level_nxt,
  output logic      mode_nxt
);

  logic        mode_r, level_r, saved_r, endless_r;
  logic [15:0] half_r, tick_r, cyc_r;
  logic        saved_nxt, endless_nxt;
  logic [15:0] half_nxt, tick_nxt, cyc_nxt;
  logic [15:0] tick_inc, cyc_dec;

  // Next channel state for the command of this cycle.
  always_comb begin
    mode_nxt    = mode_r;
    level_nxt   = level_r;
    saved_nxt   = saved_r;
    endless_nxt = endless_r;
    half_nxt    = half_r;
    tick_nxt    = tick_r;
    cyc_nxt     = cyc_r;
    tick_inc    = tick_r + 16'd1;
    cyc_dec     = (cyc_r != 16'd0) ? cyc_r - 16'd1 : 16'd0;
    case (cmd.op)
      OP_SET: begin
        mode_nxt  = 1'b0;
        level_nxt = cmd.level;
      end
      OP_TOGGLE: begin
        mode_nxt  = 1'b0;
        level_nxt = ~level_r;
      end
      OP_BLINK: begin
        mode_nxt    = 1'b1;
        saved_nxt   = level_r;
        level_nxt   = ~level_r;
        half_nxt    = cmd.interval;
        tick_nxt    = 16'd0;
        cyc_nxt     = cmd.cycles;
        endless_nxt = cmd.endless;
      end
      OP_STOP: begin
        mode_nxt  = 1'b0;
        level_nxt = saved_r;
      end
      OP_TICK: begin
        if (mode_r) begin
          if (tick_inc < half_r) begin
            tick_nxt = tick_inc;
          end else begin
            tick_nxt  = 16'd0;
            level_nxt = ~level_r;
            // In counted mode a return to the saved level uses up one cycle.
            if (!endless_r && (~level_r == saved_r)) begin
              cyc_nxt = cyc_dec;
              if (cyc_dec == 16'd0) begin
                mode_nxt = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      level_r   <= RESET_LEVEL;
      saved_r   <= 1'b0;
      endless_r <= 1'b0;
      half_r    <= 16'd0;
      tick_r    <= 16'd0;
      cyc_r     <= 16'd0;
    end else begin
      mode_r    <= mode_nxt;
      level_r   <= level_nxt;
      saved_r   <= saved_nxt;
      endless_r <= endless_nxt;
      half_r    <= half_nxt;
      tick_r    <= tick_nxt;
      cyc_r     <= cyc_nxt;
    end
  end

  // A blinking channel always has a nonzero half period.
  a_blink_half: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> (half_r != 16'd0))
    else $error("blinking channel with zero half period");

endmodule
